// ===== design/rduleb_pkg.sv =====
// Package for the range delta ULEB128 encoder.
// Holds the digit widths, ULEB128 constants and the sequencer state type.
// Depends on nothing; imported by range_delta_uleb128_encoder_top.
package rduleb_pkg;

	localparam int VALUE_W   = 64;
	localparam int DIGIT_W   = 8;
	localparam int NUM_DIGITS = VALUE_W / DIGIT_W;
	localparam int CNT_W     = $clog2(NUM_DIGITS);
	localparam int GROUP_W   = 7;
	localparam int BYTE_W    = 8;

	localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(NUM_DIGITS - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CALC = 4'b0010,
		S_GAP  = 4'b0100,
		S_LEN  = 4'b1000
	} state_t;

endpackage

// ===== design/range_delta_uleb128_encoder_top.sv =====
// Range delta ULEB128 encoder: filters ranges, codes them against the previous end.
// Serial byte-digit arithmetic followed by 7-bit group emission.
// Depends on rduleb_pkg.
//
// Channel  Direction  Handshake               Payload
// s_axis   in         s_axis_tvalid/tready    tdata {range_length, range_offset}, tuser restart
// m_axis   out        m_axis_tvalid/tready    tdata code_byte, tlast last_of_range
// cfg      in         cfg_valid/cfg_ready     cfg_data minimum kept range length
//
// A range is transferred, then runs byte-serial arithmetic over its eight digits through
// four separate 8-bit adders, then emits one ULEB128 byte per cycle unless the output
// stalls (2 to 20 bytes). A skipped range frees the input once the arithmetic ends.
// The output register lets a new range transfer while the last byte still waits.
// A stalled output holds the byte sequencer, and configuration waits out the arithmetic
// cycles; reset clears the previous end and the minimum length.
module range_delta_uleb128_encoder_top
	import rduleb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [63:0] range_offset, [127:64] range_length
	input  logic [2*VALUE_W-1:0] s_axis_tdata,
	// [0] restart
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [7:0] code_byte
	output logic [BYTE_W-1:0]    m_axis_tdata,
	output logic                 m_axis_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [VALUE_W-1:0]   cfg_data
);

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [VALUE_W-1:0]   off_q;
	logic [VALUE_W-1:0]   len_q;
	logic [VALUE_W-1:0]   end_q;
	logic [VALUE_W-1:0]   prev_q;
	logic [VALUE_W-1:0]   min_q;
	logic                 c_gap_q;
	logic                 c_lm1_q;
	logic                 c_cmp_q;
	logic                 c_end_q;
	logic [BYTE_W-1:0]    out_data_q;
	logic                 out_last_q;
	logic                 out_valid_q;

	logic                 in_xfer;
	logic                 out_free;
	logic                 out_load;
	logic                 first_d;
	logic [VALUE_W-1:0]   prev_start;
	logic [DIGIT_W:0]     sum_gap;
	logic [DIGIT_W:0]     sum_lm1;
	logic [DIGIT_W:0]     sum_cmp;
	logic [DIGIT_W:0]     sum_end;
	logic [VALUE_W-1:0]   emit_v;
	logic                 emit_more;
	logic [BYTE_W-1:0]    emit_byte;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = (state_q != S_CALC);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = ((state_q == S_GAP) || (state_q == S_LEN)) && out_free;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	assign prev_start = s_axis_tuser ? '0 : prev_q;
	assign first_d    = (prev_start == '0);

	assign sum_gap = {1'b0, off_q[DIGIT_W-1:0]} + {1'b0, ~prev_q[DIGIT_W-1:0]}
		+ {{DIGIT_W{1'b0}}, c_gap_q};
	assign sum_lm1 = {1'b0, len_q[DIGIT_W-1:0]} + {1'b0, {DIGIT_W{1'b1}}}
		+ {{DIGIT_W{1'b0}}, c_lm1_q};
	assign sum_cmp = {1'b0, len_q[DIGIT_W-1:0]} + {1'b0, ~min_q[DIGIT_W-1:0]}
		+ {{DIGIT_W{1'b0}}, c_cmp_q};
	assign sum_end = {1'b0, off_q[DIGIT_W-1:0]} + {1'b0, len_q[DIGIT_W-1:0]}
		+ {{DIGIT_W{1'b0}}, c_end_q};

	assign emit_v    = (state_q == S_GAP) ? off_q : len_q;
	assign emit_more = |emit_v[VALUE_W-1:GROUP_W];
	assign emit_byte = {emit_more, emit_v[GROUP_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			prev_q      <= '0;
			min_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				min_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						prev_q  <= prev_start;
						cnt_q   <= '0;
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					min_q  <= {min_q[DIGIT_W-1:0], min_q[VALUE_W-1:DIGIT_W]};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == LAST_DIGIT && sum_cmp[DIGIT_W]) begin
						prev_q  <= {sum_end[DIGIT_W-1:0], end_q[VALUE_W-1:DIGIT_W]};
						state_q <= S_GAP;
					end else begin
						prev_q <= {prev_q[DIGIT_W-1:0], prev_q[VALUE_W-1:DIGIT_W]};
						if (cnt_q == LAST_DIGIT) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_GAP: begin
					if (out_free && !emit_more) begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					if (out_free && !emit_more) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					off_q   <= s_axis_tdata[VALUE_W-1:0];
					len_q   <= s_axis_tdata[2*VALUE_W-1:VALUE_W];
					c_gap_q <= first_d;
					c_lm1_q <= 1'b0;
					c_cmp_q <= 1'b1;
					c_end_q <= 1'b0;
				end
			end
			S_CALC: begin
				off_q   <= {sum_gap[DIGIT_W-1:0], off_q[VALUE_W-1:DIGIT_W]};
				len_q   <= {sum_lm1[DIGIT_W-1:0], len_q[VALUE_W-1:DIGIT_W]};
				end_q   <= {sum_end[DIGIT_W-1:0], end_q[VALUE_W-1:DIGIT_W]};
				c_gap_q <= sum_gap[DIGIT_W];
				c_lm1_q <= sum_lm1[DIGIT_W];
				c_cmp_q <= sum_cmp[DIGIT_W];
				c_end_q <= sum_end[DIGIT_W];
			end
			S_GAP: begin
				if (out_free) begin
					out_data_q <= emit_byte;
					out_last_q <= 1'b0;
					off_q      <= off_q >> GROUP_W;
				end
			end
			S_LEN: begin
				if (out_free) begin
					out_data_q <= emit_byte;
					out_last_q <= !emit_more;
					len_q      <= len_q >> GROUP_W;
				end
			end
			default: begin
			end
		endcase
	end

	a_keep_goes_to_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC && cnt_q == LAST_DIGIT && sum_cmp[DIGIT_W]) |=> (state_q == S_GAP))
		else $error("kept range did not start gap emission");

	a_last_has_no_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> !m_axis_tdata[GROUP_W])
		else $error("final byte of a range carries the continuation bit");

	a_new_last_from_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast && !$past(m_axis_tvalid && !m_axis_tready))
		|-> $past(state_q == S_LEN))
		else $error("last byte loaded outside length emission");

endmodule

// ===== dv/range_delta_uleb128_encoder_top_tb.sv =====
// Self-checking testbench for range_delta_uleb128_encoder_top: a directed table, then random range
// lists under several minimum lengths, with random stalls on both streams and one long output hold.
// Depends on rduleb_pkg and the encoder RTL only.
module range_delta_uleb128_encoder_top_tb
	import rduleb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT     = 2_000_000;
	localparam int SETTLE_CYCLES   = 16;
	localparam int LONG_HOLD       = 600;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int NUM_PHASES      = 6;
	localparam int NUM_DIRECTED    = 18;
	localparam logic [VALUE_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic [BYTE_W-1:0] code;
		logic              last;
	} code_t;

	typedef enum logic [1:0] {
		ROW_CHECKED,
		ROW_PREDICTED,
		ROW_CONFIG
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic               restart;
		logic [VALUE_W-1:0] offset;
		logic [VALUE_W-1:0] length;
		logic [4:0]         count;
		logic [159:0]       codes;
	} directed_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [2*VALUE_W-1:0] s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [BYTE_W-1:0]    m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [VALUE_W-1:0]   cfg_data = '0;

	logic [VALUE_W-1:0] pred_end = '0;
	logic [VALUE_W-1:0] min_keep_len = '0;
	logic [VALUE_W-1:0] gen_end = '0;
	code_t              fresh_codes[$];
	code_t              expected_codes[$];
	int unsigned        mismatches = 0;
	int unsigned        codes_seen = 0;
	int unsigned        cycle_count = 0;
	int unsigned        ready_hold = 0;
	int unsigned        ready_calm = 0;
	int unsigned        send_calm = 0;
	int unsigned        stall_pick;
	bit                 hold_request = 1'b0;

	directed_row_t directed_rows [NUM_DIRECTED] = '{
		'{ROW_CHECKED, 1'b0, 64'h0, 64'h1, 5'd2, 160'h0},
		'{ROW_CHECKED, 1'b0, 64'h1, 64'h1, 5'd11, 160'h0001_ffff_ffff_ffff_ffff_ff},
		'{ROW_CHECKED, 1'b1, 64'h0, 64'h0, 5'd11, 160'h01_ffff_ffff_ffff_ffff_ff00},
		'{ROW_CHECKED, 1'b0, ALL_ONES, ALL_ONES, 5'd20,
			160'h01_ffff_ffff_ffff_ffff_fe01_ffff_ffff_ffff_ffff_ff},
		'{ROW_CHECKED, 1'b1, 64'h80, 64'h81, 5'd4, 160'h0180_0180},
		'{ROW_CHECKED, 1'b0, 64'h181, 64'h2, 5'd2, 160'h017f},
		'{ROW_PREDICTED, 1'b0, 64'hffff_ffff_ffff_fff0, 64'h10, 5'd0, 160'h0},
		'{ROW_CHECKED, 1'b0, 64'h5, 64'h3, 5'd2, 160'h0205},
		'{ROW_CONFIG, 1'b0, 64'h0, 64'h4, 5'd0, 160'h0},
		'{ROW_CHECKED, 1'b0, 64'h10, 64'h3, 5'd0, 160'h0},
		'{ROW_CHECKED, 1'b1, 64'h20, 64'h2, 5'd0, 160'h0},
		'{ROW_CHECKED, 1'b0, 64'h30, 64'h4, 5'd2, 160'h0330},
		'{ROW_CONFIG, 1'b0, 64'h0, ALL_ONES, 5'd0, 160'h0},
		'{ROW_CHECKED, 1'b0, 64'h100, ALL_ONES - 64'h1, 5'd0, 160'h0},
		'{ROW_PREDICTED, 1'b0, 64'h100, ALL_ONES, 5'd0, 160'h0},
		'{ROW_CONFIG, 1'b0, 64'h0, 64'h0, 5'd0, 160'h0},
		'{ROW_PREDICTED, 1'b1, 64'h0123_4567_89ab_cdef, 64'h0000_00ff_0000_0001, 5'd0, 160'h0},
		'{ROW_PREDICTED, 1'b0, 64'h0123_4567_89ab_cd00, 64'h7, 5'd0, 160'h0}
	};

	range_delta_uleb128_encoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void append_uleb(input logic [VALUE_W-1:0] value);
		logic [VALUE_W-1:0] rest;
		code_t              item;
		rest = value;
		do begin
			item.code = {rest > VALUE_W'(8'h7f), rest[GROUP_W-1:0]};
			item.last = 1'b0;
			fresh_codes.push_back(item);
			rest = rest >> GROUP_W;
		end while (rest != '0);
	endfunction

	function automatic void encode_range(input logic restart, input logic [VALUE_W-1:0] offset,
			input logic [VALUE_W-1:0] length);
		logic [VALUE_W-1:0] gap;
		fresh_codes.delete();
		if (restart)
			pred_end = '0;
		if (length >= min_keep_len) begin
			gap = offset - pred_end;
			if (pred_end != '0)
				gap = gap - 1'b1;
			append_uleb(gap);
			append_uleb(length - 1'b1);
			fresh_codes[fresh_codes.size() - 1].last = 1'b1;
			pred_end = offset + length;
		end
	endfunction

	function automatic int unsigned pick_send_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		if (r < 3) begin
			send_calm = $urandom_range(30, 120);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [VALUE_W-1:0] next_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return VALUE_W'($urandom_range(1, 200));
		if (r < 60)
			return VALUE_W'($urandom_range(1, 1 << 20));
		if (r < 72)
			return {$urandom(), $urandom()};
		if (r < 88)
			return min_keep_len + VALUE_W'($urandom_range(0, 2)) - 1'b1;
		if (r < 92)
			return '0;
		if (r < 96)
			return ALL_ONES;
		return VALUE_W'(1) << $urandom_range(0, 63);
	endfunction

	function automatic logic [VALUE_W-1:0] next_offset(input logic [VALUE_W-1:0] length);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return gen_end + VALUE_W'($urandom_range(0, 300));
		if (r < 80)
			return gen_end + (VALUE_W'(1) << $urandom_range(7, 62));
		if (r < 88)
			return {$urandom(), $urandom()};
		if (r < 94)
			return gen_end - VALUE_W'($urandom_range(1, 50));
		return '0 - length;
	endfunction

	task automatic send_range(input logic restart, input logic [VALUE_W-1:0] offset,
			input logic [VALUE_W-1:0] length, input bit typed, input int unsigned count,
			input logic [159:0] codes);
		int unsigned gap;
		code_t       item;
		gap = pick_send_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {length, offset};
		s_axis_tuser <= restart;
		do @(posedge clk); while (!s_axis_tready);
		encode_range(restart, offset, length);
		if (typed) begin
			for (int i = 0; i < count; i++) begin
				item.code = codes[8*i +: 8];
				item.last = (i == count - 1);
				expected_codes.push_back(item);
			end
		end else begin
			foreach (fresh_codes[i])
				expected_codes.push_back(fresh_codes[i]);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_codes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_keep_len(input logic [VALUE_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		min_keep_len = value;
	endtask

	function automatic logic [VALUE_W-1:0] phase_min_keep_len(input int phase);
		unique case (phase)
			0: return '0;
			1: return VALUE_W'($urandom_range(1, 40));
			2: return VALUE_W'(1) << $urandom_range(8, 40);
			3: return ALL_ONES;
			4: return {$urandom(), $urandom()};
			default: return VALUE_W'(1);
		endcase
	endfunction

	always @(posedge clk) begin
		stall_pick = $urandom_range(0, 99);
		if (ready_hold > 0) begin
			ready_hold--;
			m_axis_tready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			ready_hold = LONG_HOLD - 1;
			m_axis_tready <= 1'b0;
		end else if (ready_calm > 0) begin
			ready_calm--;
			m_axis_tready <= 1'b1;
		end else begin
			if (stall_pick < 3)
				ready_calm = $urandom_range(40, 150);
			else if (stall_pick < 20)
				ready_hold = $urandom_range(1, 3);
			else if (stall_pick < 23)
				ready_hold = $urandom_range(8, 40);
			m_axis_tready <= (ready_hold == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			codes_seen++;
			if (expected_codes.size() == 0) begin
				$display("%0t: unexpected byte %02h last %0b", $time, m_axis_tdata, m_axis_tlast);
				mismatches++;
			end else if (m_axis_tdata !== expected_codes[0].code
					|| m_axis_tlast !== expected_codes[0].last) begin
				$display("%0t: byte %0d expected %02h last %0b, got %02h last %0b", $time,
					codes_seen, expected_codes[0].code, expected_codes[0].last,
					m_axis_tdata, m_axis_tlast);
				mismatches++;
				void'(expected_codes.pop_front());
			end else begin
				void'(expected_codes.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic               restart_v;
		logic [VALUE_W-1:0] offset_v;
		logic [VALUE_W-1:0] length_v;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CONFIG)
				write_min_keep_len(directed_rows[i].length);
			else
				send_range(directed_rows[i].restart, directed_rows[i].offset,
					directed_rows[i].length, directed_rows[i].kind == ROW_CHECKED,
					directed_rows[i].count, directed_rows[i].codes);
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			write_min_keep_len(phase_min_keep_len(phase));
			if (phase == 0)
				hold_request = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				restart_v = ($urandom_range(0, 19) == 0);
				length_v = next_length();
				offset_v = next_offset(length_v);
				gen_end = offset_v + length_v;
				send_range(restart_v, offset_v, length_v, 1'b0, 0, '0);
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
design/rduleb_pkg.sv
design/range_delta_uleb128_encoder_top.sv
dv/range_delta_uleb128_encoder_top_tb.sv
